@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the serial core RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// cond must never be true at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/dsnm_pkg.sv @@
// Types and constants for the next-serial core.
// No dependencies; used by every module under rtl/core.
package dsnm_pkg;

    localparam int SERIAL_W = 32;
    localparam int MOD_W    = 8;

    typedef logic [SERIAL_W-1:0] serial_t;
    typedef logic [MOD_W-1:0]    mod_t;
    typedef logic [1:0]          policy_t;
    typedef logic [1:0]          cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t CFG_POLICY  = 2'd0;
    localparam cfg_index_t CFG_RESIDUE = 2'd1;
    localparam cfg_index_t CFG_DIVISOR = 2'd2;
    localparam cfg_index_t CFG_OFFSET  = 2'd3;

    // policy codes; anything else behaves as increment
    localparam policy_t POLICY_INCR = 2'd0;
    localparam policy_t POLICY_TIME = 2'd1;
    localparam policy_t POLICY_DATE = 2'd2;

    localparam serial_t YEAR_SCALE  = 32'd1000000;
    localparam serial_t MONTH_SCALE = 32'd10000;
    localparam serial_t DAY_SCALE   = 32'd100;

    // item travelling down the remainder chain
    typedef struct packed {
        serial_t value;
        mod_t    rem;
        logic    used;
        logic    bad;
    } dsnm_item_t;

endpackage

@@ rtl/core/dsnm_front.sv @@
// Front end: base selection (incl. date serial), candidate and RFC 1982 compare.
// Two register stages; depends on dsnm_pkg.
module dsnm_front
    import dsnm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  policy_t      policy,
    input  serial_t      offset,
    input  logic         bad_cfg,
    input  logic         in_valid,
    output logic         in_stall,
    input  serial_t      current_serial,
    input  serial_t      forced_step,
    input  serial_t      unix_seconds,
    input  logic [12:0]  date_year,
    input  logic [3:0]   date_month,
    input  logic [4:0]   date_day,
    input  logic         date_valid,
    output logic         out_valid,
    output dsnm_item_t   out_item,
    input  logic         out_stall
);

    logic        s1_valid_reg;
    serial_t     current_reg;
    serial_t     step_reg;
    serial_t     base_reg;
    serial_t     base_next;
    logic        s1_stall;

    logic        s2_valid_reg;
    dsnm_item_t  s2_item_reg;
    dsnm_item_t  s2_item_next;
    logic        s2_stall;

    logic [32:0] year_prod;
    logic [17:0] month_term;
    logic [11:0] day_term;
    serial_t     date_base;
    serial_t     cand;
    serial_t     diff;
    logic        cand_gt;

    assign s2_stall = s2_valid_reg && out_stall;
    assign s1_stall = s1_valid_reg && s2_stall;
    assign in_stall = s1_stall;

    // stage 1: policy base, date serial taken mod 2^32
    always_comb
    begin
        year_prod  = 33'(date_year) * 33'(YEAR_SCALE);
        month_term = 18'(date_month) * 18'(MONTH_SCALE);
        day_term   = 12'(date_day) * 12'(DAY_SCALE);
        date_base  = date_valid
                   ? (year_prod[31:0] + 32'(month_term) + 32'(day_term))
                   : current_serial;
        case (policy)
            POLICY_TIME: base_next = unix_seconds;
            POLICY_DATE: base_next = date_base;
            default:     base_next = current_serial;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!s1_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!s1_stall && in_valid)
        begin
            current_reg <= current_serial;
            step_reg    <= forced_step;
            base_reg    <= base_next;
        end
    end

    // stage 2: candidate, serial greater-than, result choice
    always_comb
    begin
        cand    = base_reg + offset;
        diff    = cand - current_reg;
        // distance of exactly 2^31 is incomparable, so not greater
        cand_gt = !diff[SERIAL_W-1] && (diff[SERIAL_W-2:0] != '0);
        s2_item_next.rem  = '0;
        s2_item_next.bad  = bad_cfg;
        s2_item_next.used = cand_gt && !bad_cfg;
        if (bad_cfg)
            s2_item_next.value = current_reg;
        else if (cand_gt)
            s2_item_next.value = cand;
        else
            s2_item_next.value = current_reg + step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (!s2_stall)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!s2_stall && s1_valid_reg)
            s2_item_reg <= s2_item_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

@@ rtl/core/dsnm_rem_cell.sv @@
// One cell of the remainder chain: folds STEP_BITS bits of the value into rem.
// Restoring steps against the divisor; depends on dsnm_pkg.
module dsnm_rem_cell
    import dsnm_pkg::*;
#(
    parameter int STEP_BITS = 4,
    parameter int MSB_POS   = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mod_t        divisor,
    input  logic        in_valid,
    input  dsnm_item_t  in_item,
    output logic        in_stall,
    output logic        out_valid,
    output dsnm_item_t  out_item,
    input  logic        out_stall
);

    logic        valid_reg;
    dsnm_item_t  item_reg;
    dsnm_item_t  item_next;

    assign in_stall = valid_reg && out_stall;

    always_comb
    begin
        logic [MOD_W-1:0] r;
        logic [MOD_W:0]   t;
        r = in_item.rem;
        t = '0;
        // rem stays below divisor, so t stays below twice divisor
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, in_item.value[MSB_POS-i]};
            if (t >= {1'b0, divisor})
                t = t - {1'b0, divisor};
            r = t[MOD_W-1:0];
        end
        item_next     = in_item;
        item_next.rem = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ rtl/core/dsnm_align.sv @@
// Final stage: raise the value to the next residue class, flag 32-bit wrap.
// Holds the output register; depends on dsnm_pkg.
module dsnm_align
    import dsnm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mod_t        residue,
    input  mod_t        divisor,
    input  logic        in_valid,
    input  dsnm_item_t  in_item,
    output logic        in_stall,
    output logic        out_valid,
    output serial_t     next_serial,
    output logic        candidate_used,
    output logic        wrapped,
    output logic        bad_config,
    input  logic        out_stall
);

    logic           valid_reg;
    serial_t        result_reg;
    serial_t        result_next;
    logic           used_reg;
    logic           wrap_reg;
    logic           wrap_next;
    logic           bad_reg;

    logic [MOD_W:0] gap;
    mod_t           incr;
    logic [SERIAL_W:0] sum;

    assign in_stall = valid_reg && out_stall;

    always_comb
    begin
        // (residue + divisor - rem) lies in 1 .. 2*divisor-1
        gap  = {1'b0, residue} + {1'b0, divisor} - {1'b0, in_item.rem};
        incr = (gap >= {1'b0, divisor}) ? MOD_W'(gap - {1'b0, divisor})
                                        : gap[MOD_W-1:0];
        sum  = {1'b0, in_item.value} + (SERIAL_W+1)'(incr);
        wrap_next = sum[SERIAL_W] && !in_item.bad;
        if (in_item.bad)
            result_next = in_item.value;
        else if (sum[SERIAL_W])
            result_next = SERIAL_W'(residue);
        else
            result_next = sum[SERIAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            result_reg <= result_next;
            used_reg   <= in_item.used;
            wrap_reg   <= wrap_next;
            bad_reg    <= in_item.bad;
        end
    end

    assign out_valid      = valid_reg;
    assign next_serial    = result_reg;
    assign candidate_used = used_reg;
    assign wrapped        = wrap_reg;
    assign bad_config     = bad_reg;

endmodule

@@ rtl/core/dns_serial_next_modulo_core.sv @@
// Next zone serial core: RFC 1982 candidate check plus residue alignment.
// Top level; depends on dsnm_pkg, dsnm_front, dsnm_rem_cell, dsnm_align.
//
// Input channel in_valid/in_stall carries one request item; output channel
// out_valid/out_stall carries one result item per request, in order.
// Configuration: cfg_we with cfg_index/cfg_data writes policy, residue,
// divisor or offset; write only while no item is in flight.
// Registers from accept to out_valid: two front stages, the remainder chain,
// one output register. Throughput is one item per cycle while the receiver
// does not stall; each remainder cell does BITS_PER_CELL (default 4)
// restoring steps on an 8-bit remainder.
// When the receiver stalls, the output register holds; items behind it keep
// moving into empty stages, and in_stall rises only once every stage is full.
// Reset empties the pipeline and loads policy 0, residue 0, divisor 1,
// offset 0.
`include "assert_macros.svh"

module dns_serial_next_modulo_core
    import dsnm_pkg::*;
#(
    parameter int BITS_PER_CELL = 4   // must divide 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  cfg_index_t   cfg_index,
    input  serial_t      cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  serial_t      current_serial,
    input  serial_t      forced_step,
    input  serial_t      unix_seconds,
    input  logic [12:0]  date_year,
    input  logic [3:0]   date_month,
    input  logic [4:0]   date_day,
    input  logic         date_valid,
    output logic         out_valid,
    input  logic         out_stall,
    output serial_t      next_serial,
    output logic         candidate_used,
    output logic         wrapped,
    output logic         bad_config
);

    localparam int NUM_CELLS = SERIAL_W / BITS_PER_CELL;

    policy_t     policy_reg;
    mod_t        residue_reg;
    mod_t        divisor_reg;
    serial_t     offset_reg;
    logic        bad_cfg;

    logic        cell_valid [0:NUM_CELLS];
    logic        cell_stall [0:NUM_CELLS];
    dsnm_item_t  cell_item  [0:NUM_CELLS];
    logic [NUM_CELLS:0] valid_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POLICY_INCR;
            residue_reg <= '0;
            divisor_reg <= MOD_W'(1);
            offset_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLICY:  policy_reg  <= cfg_data[1:0];
                CFG_RESIDUE: residue_reg <= cfg_data[MOD_W-1:0];
                CFG_DIVISOR: divisor_reg <= cfg_data[MOD_W-1:0];
                CFG_OFFSET:  offset_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // covers divisor zero as well
    assign bad_cfg = (residue_reg >= divisor_reg);

    dsnm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .policy         (policy_reg),
        .offset         (offset_reg),
        .bad_cfg        (bad_cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .current_serial (current_serial),
        .forced_step    (forced_step),
        .unix_seconds   (unix_seconds),
        .date_year      (date_year),
        .date_month     (date_month),
        .date_day       (date_day),
        .date_valid     (date_valid),
        .out_valid      (cell_valid[0]),
        .out_item       (cell_item[0]),
        .out_stall      (cell_stall[0])
    );

    // remainder chain, most significant bits first
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        dsnm_rem_cell #(
            .STEP_BITS (BITS_PER_CELL),
            .MSB_POS   (SERIAL_W - 1 - k * BITS_PER_CELL)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (divisor_reg),
            .in_valid  (cell_valid[k]),
            .in_item   (cell_item[k]),
            .in_stall  (cell_stall[k]),
            .out_valid (cell_valid[k+1]),
            .out_item  (cell_item[k+1]),
            .out_stall (cell_stall[k+1])
        );
    end

    dsnm_align u_align (
        .clk            (clk),
        .rst_n          (rst_n),
        .residue        (residue_reg),
        .divisor        (divisor_reg),
        .in_valid       (cell_valid[NUM_CELLS]),
        .in_item        (cell_item[NUM_CELLS]),
        .in_stall       (cell_stall[NUM_CELLS]),
        .out_valid      (out_valid),
        .next_serial    (next_serial),
        .candidate_used (candidate_used),
        .wrapped        (wrapped),
        .bad_config     (bad_config),
        .out_stall      (out_stall)
    );

    always_comb
    begin
        for (int i = 0; i <= NUM_CELLS; i++)
            valid_vec[i] = cell_valid[i];
    end

    // back-pressure reaches the input only through a completely full pipe
    `ASSERT_CLK(a_stall_full, clk, rst_n, in_stall |-> (&valid_vec && out_valid && out_stall))
    // a bad-config result never reports a used candidate or a wrap
    `ASSERT_NEVER(a_bad_clean, clk, rst_n, out_valid && bad_config && (candidate_used || wrapped))
    // a result only appears after the last cell held an item
    `ASSERT_CLK(a_out_source, clk, rst_n, $rose(out_valid) |-> $past(cell_valid[NUM_CELLS]))

endmodule

@@ dv/dns_serial_next_modulo_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for dns_serial_next_modulo_core: directed rows, then random items under
// changing register settings and idling. Depends on dsnm_pkg and the core RTL only.
module dns_serial_next_modulo_core_test;
    import dsnm_pkg::*;

    localparam int          DIR_ROWS     = 24;
    localparam int          SEGMENTS     = 37;
    localparam int          SEG_ITEMS    = 50;
    localparam int          HOLD_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // unnamed policy code, decodes as increment
    localparam policy_t     POLICY_ALIAS = 2'd3;

    typedef struct packed {
        policy_t policy;
        mod_t    residue;
        mod_t    divisor;
        serial_t offset;
    } cfg_t;

    typedef struct packed {
        serial_t     cur;
        serial_t     step;
        serial_t     unix;
        logic [12:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        dvalid;
    } req_t;

    typedef struct packed {
        serial_t serial;
        logic    used;
        logic    wrapped;
        logic    bad;
    } res_t;

    typedef struct packed {
        cfg_t cfg;
        req_t req;
        logic chk;
        res_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = CFG_POLICY;
    serial_t     cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    serial_t     current_serial = '0;
    serial_t     forced_step = '0;
    serial_t     unix_seconds = '0;
    logic [12:0] date_year = '0;
    logic [3:0]  date_month = '0;
    logic [4:0]  date_day = '0;
    logic        date_valid = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    serial_t     next_serial;
    logic        candidate_used;
    logic        wrapped;
    logic        bad_config;

    dns_serial_next_modulo_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .current_serial (current_serial),
        .forced_step    (forced_step),
        .unix_seconds   (unix_seconds),
        .date_year      (date_year),
        .date_month     (date_month),
        .date_day       (date_day),
        .date_valid     (date_valid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .next_serial    (next_serial),
        .candidate_used (candidate_used),
        .wrapped        (wrapped),
        .bad_config     (bad_config)
    );

    cfg_t        active_cfg = '{POLICY_INCR, 8'd0, 8'd1, 32'h0};
    res_t        pending_serials [$];
    res_t        oldest_serial;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned results_checked = 0;
    int unsigned used_seen = 0;
    int unsigned wrap_seen = 0;
    int unsigned bad_seen = 0;
    int unsigned cfg_loads = 0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // reset settings
        '{'{POLICY_INCR, 8'd0, 8'd1, 32'h0},
          '{32'h0, 32'h0, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{'{POLICY_INCR, 8'd0, 8'd1, 32'h0},
          '{32'hffffffff, 32'h1, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{'{POLICY_INCR, 8'd0, 8'd1, 32'h0},
          '{32'h5, 32'hffffffff, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'h4, 1'b0, 1'b0, 1'b0}},
        '{'{POLICY_INCR, 8'd0, 8'd1, 32'h1},
          '{32'hffffffff, 32'h0, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'h0, 1'b1, 1'b0, 1'b0}},
        // distance of exactly half the space is not greater
        '{'{POLICY_INCR, 8'd0, 8'd1, 32'h80000000},
          '{32'h12345678, 32'h1, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'h12345679, 1'b0, 1'b0, 1'b0}},
        '{'{POLICY_INCR, 8'd0, 8'd1, 32'h7fffffff},
          '{32'h0, 32'h9, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'h7fffffff, 1'b1, 1'b0, 1'b0}},
        '{'{POLICY_INCR, 8'd0, 8'd1, 32'hffffffff},
          '{32'h5, 32'h0, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'h5, 1'b0, 1'b0, 1'b0}},
        '{'{POLICY_ALIAS, 8'd0, 8'd1, 32'h2},
          '{32'd10, 32'h0, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'd12, 1'b1, 1'b0, 1'b0}},
        '{'{POLICY_TIME, 8'd0, 8'd1, 32'h0},
          '{32'd100, 32'h0, 32'd200, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'd200, 1'b1, 1'b0, 1'b0}},
        '{'{POLICY_TIME, 8'd0, 8'd1, 32'h0},
          '{32'd200, 32'd3, 32'd100, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'd203, 1'b0, 1'b0, 1'b0}},
        '{'{POLICY_TIME, 8'd0, 8'd1, 32'h0},
          '{32'hffffffff, 32'h0, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'h0, 1'b1, 1'b0, 1'b0}},
        '{'{POLICY_DATE, 8'd0, 8'd1, 32'h0},
          '{32'h0, 32'h0, 32'h0, 13'd2024, 4'd5, 5'd17, 1'b1}, 1'b1,
          '{32'd2024051700, 1'b1, 1'b0, 1'b0}},
        // invalid date falls back to current
        '{'{POLICY_DATE, 8'd0, 8'd1, 32'h0},
          '{32'd7, 32'd1, 32'h0, 13'd2024, 4'd5, 5'd17, 1'b0}, 1'b1,
          '{32'd8, 1'b0, 1'b0, 1'b0}},
        // out-of-range date fields, not range checked
        '{'{POLICY_DATE, 8'd0, 8'd1, 32'h0},
          '{32'h10, 32'd1, 32'h0, 13'd8191, 4'd15, 5'd31, 1'b1}, 1'b0, '0},
        '{'{POLICY_DATE, 8'd0, 8'd1, 32'h0},
          '{32'hfff00000, 32'd2, 32'h0, 13'd4294, 4'd12, 5'd31, 1'b1}, 1'b0, '0},
        '{'{POLICY_DATE, 8'd0, 8'd1, 32'h0},
          '{32'h0, 32'h0, 32'h0, 13'd0, 4'd0, 5'd0, 1'b1}, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
        // widest alignment: all-ones is a multiple of 255, so it wraps
        '{'{POLICY_INCR, 8'd254, 8'd255, 32'h0},
          '{32'hffffffff, 32'h0, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'd254, 1'b0, 1'b1, 1'b0}},
        '{'{POLICY_INCR, 8'd254, 8'd255, 32'h0},
          '{32'h0, 32'h0, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'd254, 1'b0, 1'b0, 1'b0}},
        '{'{POLICY_INCR, 8'd254, 8'd255, 32'h0},
          '{32'h89abcdef, 32'h1111, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b0, '0},
        // bad settings (residue equal to divisor, divisor zero, residue above divisor), then good ones
        '{'{POLICY_INCR, 8'd5, 8'd5, 32'h0},
          '{32'hdeadbeef, 32'h1, 32'h0, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'hdeadbeef, 1'b0, 1'b0, 1'b1}},
        '{'{POLICY_TIME, 8'd0, 8'd0, 32'h10},
          '{32'h1234, 32'h1, 32'hffff0000, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b1,
          '{32'h1234, 1'b0, 1'b0, 1'b1}},
        '{'{POLICY_DATE, 8'd255, 8'd1, 32'h0},
          '{32'hffffffff, 32'h0, 32'h0, 13'd2024, 4'd5, 5'd17, 1'b1}, 1'b1,
          '{32'hffffffff, 1'b0, 1'b0, 1'b1}},
        '{'{POLICY_TIME, 8'd7, 8'd16, 32'hfffff000},
          '{32'hfffff000, 32'h0, 32'hffffffff, 13'd1900, 4'd1, 5'd1, 1'b0}, 1'b0, '0},
        '{'{POLICY_DATE, 8'd3, 8'd200, 32'h64},
          '{32'h0, 32'h0, 32'h0, 13'd2099, 4'd12, 5'd31, 1'b1}, 1'b0, '0}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic serial_t date_serial(req_t r);
        return {19'd0, r.year} * YEAR_SCALE + {28'd0, r.month} * MONTH_SCALE
             + {27'd0, r.day} * DAY_SCALE;
    endfunction

    function automatic res_t next_serial_for(req_t r);
        res_t        o;
        serial_t     base;
        serial_t     cand;
        serial_t     fwd;
        serial_t     result;
        serial_t     rmod;
        serial_t     incr;
        logic [32:0] sum;
        o = '0;
        if (active_cfg.residue >= active_cfg.divisor)
        begin
            o.serial = r.cur;
            o.bad    = 1'b1;
            return o;
        end
        case (active_cfg.policy)
            POLICY_TIME: base = r.unix;
            POLICY_DATE: base = r.dvalid ? date_serial(r) : r.cur;
            default:     base = r.cur;
        endcase
        cand = base + active_cfg.offset;
        fwd  = cand - r.cur;
        // serially greater: forward distance nonzero and under half the space
        if (!fwd[31] && fwd[30:0] != '0)
        begin
            result = cand;
            o.used = 1'b1;
        end
        else
            result = r.cur + r.step;
        rmod = result % {24'd0, active_cfg.divisor};
        incr = ({24'd0, active_cfg.residue} + {24'd0, active_cfg.divisor} - rmod)
             % {24'd0, active_cfg.divisor};
        sum = {1'b0, result} + {1'b0, incr};
        if (sum[32])
        begin
            o.serial  = {24'd0, active_cfg.residue};
            o.wrapped = 1'b1;
        end
        else
            o.serial = sum[31:0];
        return o;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.policy = policy_t'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:
            begin
                c.divisor = 8'd255;
                c.residue = 8'd254;
            end
            1:
            begin
                c.divisor = 8'd1;
                c.residue = 8'd0;
            end
            2:
            begin
                c.divisor = 8'd0;
                c.residue = mod_t'($urandom_range(0, 255));
            end
            3:
            begin
                c.divisor = mod_t'($urandom_range(1, 255));
                c.residue = mod_t'($urandom_range(c.divisor, 255));
            end
            default:
            begin
                c.divisor = mod_t'($urandom_range(1, 255));
                c.residue = mod_t'($urandom_range(0, c.divisor - 1));
            end
        endcase
        case ($urandom_range(0, 5))
            0:       c.offset = 32'h0;
            1:       c.offset = 32'h7fffffff;
            2:       c.offset = 32'h80000000;
            3:       c.offset = serial_t'($urandom_range(0, 2000)) - 32'd1000;
            default: c.offset = $urandom;
        endcase
        return c;
    endfunction

    function automatic req_t make_request();
        req_t        r;
        serial_t     base;
        int unsigned kind;
        kind     = $urandom_range(0, 15);
        r.unix   = $urandom;
        r.year   = 13'($urandom_range(1900, 4294));
        r.month  = 4'($urandom_range(1, 12));
        r.day    = 5'($urandom_range(1, 31));
        r.dvalid = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 5))
            0:       r.step = 32'h0;
            1:       r.step = $urandom;
            default: r.step = serial_t'($urandom_range(1, 3));
        endcase
        r.cur = $urandom;
        case (active_cfg.policy)
            POLICY_TIME: base = r.unix;
            POLICY_DATE: base = r.dvalid ? date_serial(r) : r.cur;
            default:     base = r.cur;
        endcase
        case (kind)
            // noise: every bit of every field free
            0:
            begin
                r.step   = $urandom;
                r.year   = 13'($urandom);
                r.month  = 4'($urandom);
                r.day    = 5'($urandom);
                r.dvalid = 1'($urandom);
            end
            1, 2: ;
            3, 4: r.cur = 32'hffffffff - serial_t'($urandom_range(0, 300));
            5:    r.cur = base + active_cfg.offset + 32'h80000000;
            default: r.cur = base + active_cfg.offset + 32'd32 - serial_t'($urandom_range(0, 64));
        endcase
        return r;
    endfunction

    task automatic offer_request(req_t r, logic typed, res_t typed_res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        current_serial <= r.cur;
        forced_step    <= r.step;
        unix_seconds   <= r.unix;
        date_year      <= r.year;
        date_month     <= r.month;
        date_day       <= r.day;
        date_valid     <= r.dvalid;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_serials.push_back(typed ? typed_res : next_serial_for(r));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_serials.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_settings(cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLICY;
        cfg_data  <= {30'd0, c.policy};
        @(posedge clk);
        cfg_index <= CFG_RESIDUE;
        cfg_data  <= {24'd0, c.residue};
        @(posedge clk);
        cfg_index <= CFG_DIVISOR;
        cfg_data  <= {24'd0, c.divisor};
        @(posedge clk);
        cfg_index <= CFG_OFFSET;
        cfg_data  <= c.offset;
        @(posedge clk);
        cfg_we     <= 1'b0;
        active_cfg = c;
        cfg_loads++;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_serials.size() == 0)
            begin
                $error("unexpected item: next_serial %h", next_serial);
                error_count++;
            end
            else
            begin
                oldest_serial = pending_serials.pop_front();
                results_checked++;
                if (next_serial !== oldest_serial.serial)
                begin
                    $error("next_serial: expected %h, got %h", oldest_serial.serial, next_serial);
                    error_count++;
                end
                if (candidate_used !== oldest_serial.used)
                begin
                    $error("candidate_used: expected %b, got %b", oldest_serial.used,
                           candidate_used);
                    error_count++;
                end
                if (wrapped !== oldest_serial.wrapped)
                begin
                    $error("wrapped: expected %b, got %b", oldest_serial.wrapped, wrapped);
                    error_count++;
                end
                if (bad_config !== oldest_serial.bad)
                begin
                    $error("bad_config: expected %b, got %b", oldest_serial.bad, bad_config);
                    error_count++;
                end
                used_seen += oldest_serial.used;
                wrap_seen += oldest_serial.wrapped;
                bad_seen  += oldest_serial.bad;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 79;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].cfg != active_cfg)
            begin
                drain_results();
                load_settings(dir_tab[i].cfg);
            end
            offer_request(dir_tab[i].req, dir_tab[i].chk, dir_tab[i].res);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_results();
            if (seg == 13)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 24;
            end
            else if (seg == 25)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_settings(random_settings());
            // long output hold-off while items keep coming: pipeline fills, input stalls
            if (seg == 30)
                hold_requests++;
            for (int n = 0; n < SEG_ITEMS; n++)
                offer_request(make_request(), 1'b0, '0);
        end

        drain_results();
        repeat (16) @(posedge clk);

        $display("%0d items checked across %0d register settings", results_checked, cfg_loads);
        $display("candidate taken %0d, wrapped %0d, bad config %0d; idling swapped, one hold-off",
                 used_seen, wrap_seen, bad_seen);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ dns_serial_next_modulo_core.f @@
+incdir+rtl/core
rtl/core/dsnm_pkg.sv
rtl/core/dsnm_front.sv
rtl/core/dsnm_rem_cell.sv
rtl/core/dsnm_align.sv
rtl/core/dns_serial_next_modulo_core.sv
dv/dns_serial_next_modulo_core_test.sv
